### rtl/stok_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stok_pkg
// Token codes, the token record and character class helpers for the
// source tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

    localparam logic [4:0] TT_COMMA    = 5'd0;
    localparam logic [4:0] TT_SEMI     = 5'd1;
    localparam logic [4:0] TT_PLUS     = 5'd2;
    localparam logic [4:0] TT_MINUS    = 5'd3;
    localparam logic [4:0] TT_STAR     = 5'd4;
    localparam logic [4:0] TT_GT       = 5'd5;
    localparam logic [4:0] TT_LT       = 5'd6;
    localparam logic [4:0] TT_LPAREN   = 5'd7;
    localparam logic [4:0] TT_RPAREN   = 5'd8;
    localparam logic [4:0] TT_LBRACE   = 5'd9;
    localparam logic [4:0] TT_RBRACE   = 5'd10;
    localparam logic [4:0] TT_LBRACKET = 5'd11;
    localparam logic [4:0] TT_RBRACKET = 5'd12;
    localparam logic [4:0] TT_EQ       = 5'd13;
    localparam logic [4:0] TT_ASSIGN   = 5'd14;
    localparam logic [4:0] TT_STRING   = 5'd15;
    localparam logic [4:0] TT_IDENT    = 5'd16;
    localparam logic [4:0] TT_NUMBER   = 5'd17;
    localparam logic [4:0] TT_KW0      = 5'd18;
    localparam logic [4:0] TT_END      = 5'd29;
    localparam logic [4:0] TT_ERROR    = 5'd30;

    localparam int NUM_KW = 11;

    typedef struct packed {
        logic [4:0]  ttype;
        logic [15:0] pos;
        logic [15:0] len;
        logic [31:0] hash;
    } token_t;

    // Keyword text packed first character in the lowest byte.
    function automatic logic [63:0] kw_text(input logic [3:0] idx);
        logic [63:0] t;
        case (idx)
            4'd0:    t = 64'h0000_0000_746F_726C; // lrot
            4'd1:    t = 64'h0000_0000_746F_7272; // rrot
            4'd2:    t = 64'h0000_0000_646E_616E; // nand
            4'd3:    t = 64'h0000_0000_0074_656C; // let
            4'd4:    t = 64'h0000_0074_736E_6F63; // const
            4'd5:    t = 64'h0000_0000_0000_6669; // if
            4'd6:    t = 64'h0000_0000_6E65_6874; // then
            4'd7:    t = 64'h0000_0000_6573_6C65; // else
            4'd8:    t = 64'h0000_0065_6C69_6877; // while
            4'd9:    t = 64'h0000_0000_0000_6F64; // do
            4'd10:   t = 64'h0000_0000_0000_6E66; // fn
            default: t = 64'h0;
        endcase
        return t;
    endfunction

    function automatic logic [2:0] kw_len(input logic [3:0] idx);
        logic [2:0] l;
        case (idx)
            4'd0, 4'd1, 4'd2, 4'd6, 4'd7: l = 3'd4;
            4'd3:                          l = 3'd3;
            4'd4, 4'd8:                    l = 3'd5;
            4'd5, 4'd9, 4'd10:             l = 3'd2;
            default:                       l = 3'd0;
        endcase
        return l;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

### rtl/source_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming lexer: one source character per word in, tokens out.
// ----------------------------------------------------------------------------
// An accepted input word is held in the input register; its tokens go to the
// result buffer. Throughput: one input word per cycle while each word gives
// at most one token and tok_stall is low; a word that gives more tokens holds
// the scan stage while the result buffer drains them one token per cycle.
// Reset: rst_n clears the scan state to idle at position zero and empties
// the input register and the result buffer.
module source_tokenizer #(
    parameter int KEYWORD_MAX_LEN = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_stall,
    input  logic [7:0]  ch,
    input  logic        has_char,
    input  logic        end_of_source,
    output logic        tok_valid,
    input  logic        tok_stall,
    output logic [4:0]  token_type,
    output logic [15:0] token_pos,
    output logic [15:0] token_len,
    output logic [31:0] ident_hash,
    output logic        last_of_run
);

    localparam int PW = 8 * KEYWORD_MAX_LEN;

    localparam logic [3:0] M_IDLE       = 4'd0;
    localparam logic [3:0] M_WORD       = 4'd1;
    localparam logic [3:0] M_STR        = 4'd2;
    localparam logic [3:0] M_STR_ESC    = 4'd3;
    localparam logic [3:0] M_EQ_PEND    = 4'd4;
    localparam logic [3:0] M_SLASH      = 4'd5;
    localparam logic [3:0] M_LINE       = 4'd6;
    localparam logic [3:0] M_BLOCK      = 4'd7;
    localparam logic [3:0] M_BLOCK_STAR = 4'd8;

    // Close a word: number, keyword or identifier.
    function automatic stok_pkg::token_t finish_word(
        input logic [15:0]   start,
        input logic [15:0]   len,
        input logic [31:0]   hash,
        input logic [PW-1:0] prefix,
        input logic          ident
    );
        stok_pkg::token_t t;
        logic             hit;
        logic [63:0]      kw;
        t.pos  = start;
        t.len  = len;
        t.hash = 32'd0;
        t.ttype = stok_pkg::TT_NUMBER;
        hit = 1'b0;
        kw  = 64'd0;
        if (ident)
        begin
            t.ttype = stok_pkg::TT_IDENT;
            t.hash  = hash;
            for (int i = 0; i < stok_pkg::NUM_KW; i++)
            begin
                kw = stok_pkg::kw_text(4'(i));
                if (!hit && len == 16'(stok_pkg::kw_len(4'(i)))
                    && prefix == kw[PW-1:0])
                begin
                    hit     = 1'b1;
                    t.ttype = stok_pkg::TT_KW0 + 5'(i);
                    t.hash  = 32'd0;
                end
            end
        end
        return t;
    endfunction

    // input register
    logic        in_v_reg;
    logic [7:0]  ch_reg;
    logic        has_reg;
    logic        eos_reg;

    // scan state
    logic [3:0]    mode_reg, mode_next;
    logic [15:0]   pos_reg, pos_next;
    logic [15:0]   start_reg, start_next;
    logic [15:0]   len_reg, len_next;
    logic [31:0]   hash_reg, hash_next;
    logic [PW-1:0] prefix_reg, prefix_next;
    logic          ident_reg, ident_next;

    // result buffer
    stok_pkg::token_t buf_reg [0:2];
    stok_pkg::token_t slot_next [0:2];
    logic [1:0]       cnt_reg, cnt_next;
    logic [1:0]       idx_reg;
    logic [1:0]       rd_idx;
    stok_pkg::token_t rd_tok;

    logic pop, buf_free, process, src_accept, out_last;

    // idle-state classification of the current character
    logic             idle_emit;
    stok_pkg::token_t idle_tok;
    logic [3:0]       idle_mode;
    logic             alpha, alnum;

    always_comb
    begin
        alpha          = stok_pkg::is_alpha(ch_reg);
        alnum          = alpha || stok_pkg::is_digit(ch_reg);
        idle_emit      = 1'b1;
        idle_mode      = M_IDLE;
        idle_tok.pos   = pos_reg;
        idle_tok.len   = 16'd1;
        idle_tok.hash  = 32'd0;
        idle_tok.ttype = stok_pkg::TT_ERROR;
        unique case (ch_reg)
            ",":     idle_tok.ttype = stok_pkg::TT_COMMA;
            ";":     idle_tok.ttype = stok_pkg::TT_SEMI;
            "+":     idle_tok.ttype = stok_pkg::TT_PLUS;
            "-":     idle_tok.ttype = stok_pkg::TT_MINUS;
            "*":     idle_tok.ttype = stok_pkg::TT_STAR;
            ">":     idle_tok.ttype = stok_pkg::TT_GT;
            "<":     idle_tok.ttype = stok_pkg::TT_LT;
            "(":     idle_tok.ttype = stok_pkg::TT_LPAREN;
            ")":     idle_tok.ttype = stok_pkg::TT_RPAREN;
            "{":     idle_tok.ttype = stok_pkg::TT_LBRACE;
            "}":     idle_tok.ttype = stok_pkg::TT_RBRACE;
            "[":     idle_tok.ttype = stok_pkg::TT_LBRACKET;
            "]":     idle_tok.ttype = stok_pkg::TT_RBRACKET;
            "/":
            begin
                idle_emit = 1'b0;
                idle_mode = M_SLASH;
            end
            "=":
            begin
                idle_emit = 1'b0;
                idle_mode = M_EQ_PEND;
            end
            "\"":
            begin
                idle_emit = 1'b0;
                idle_mode = M_STR;
            end
            default:
            begin
                if (stok_pkg::is_space(ch_reg))
                begin
                    idle_emit = 1'b0;
                end
                else if (alnum)
                begin
                    idle_emit = 1'b0;
                    idle_mode = M_WORD;
                end
            end
        endcase
    end

    // scan one word: character first, then end of source
    stok_pkg::token_t cand [0:3];
    logic [3:0]       cand_v;
    logic [1:0]       n_tok;

    always_comb
    begin
        logic apply_idle;
        logic [15:0] pos_a;
        mode_next   = mode_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        hash_next   = hash_reg;
        prefix_next = prefix_reg;
        ident_next  = ident_reg;
        apply_idle  = 1'b0;
        cand_v      = 4'b0000;
        for (int k = 0; k < 4; k++)
        begin
            cand[k].ttype = stok_pkg::TT_ERROR;
            cand[k].pos   = start_reg;
            cand[k].len   = 16'd1;
            cand[k].hash  = 32'd0;
        end

        if (has_reg)
        begin
            unique case (mode_reg)
                M_WORD:
                begin
                    if (alnum)
                    begin
                        if (len_reg < 16'd32)
                            hash_next = hash_reg + ({24'd0, ch_reg} << len_reg[4:0]);
                        for (int k = 0; k < KEYWORD_MAX_LEN; k++)
                        begin
                            if (len_reg == 16'(k))
                                prefix_next[8*k +: 8] = prefix_reg[8*k +: 8] | ch_reg;
                        end
                        len_next = stok_pkg::sat_inc(len_reg);
                    end
                    else
                    begin
                        cand_v[0]  = 1'b1;
                        cand[0]    = finish_word(start_reg, len_reg, hash_reg,
                                                 prefix_reg, ident_reg);
                        apply_idle = 1'b1;
                    end
                end
                M_STR:
                begin
                    len_next = stok_pkg::sat_inc(len_reg);
                    if (ch_reg == "\\")
                    begin
                        mode_next = M_STR_ESC;
                    end
                    else if (ch_reg == "\"")
                    begin
                        cand_v[0]     = 1'b1;
                        cand[0].ttype = stok_pkg::TT_STRING;
                        cand[0].len   = len_next;
                        mode_next     = M_IDLE;
                    end
                end
                M_STR_ESC:
                begin
                    len_next  = stok_pkg::sat_inc(len_reg);
                    mode_next = M_STR;
                end
                M_EQ_PEND:
                begin
                    cand_v[0] = 1'b1;
                    if (ch_reg == "=")
                    begin
                        cand[0].ttype = stok_pkg::TT_EQ;
                        cand[0].len   = 16'd2;
                        mode_next     = M_IDLE;
                    end
                    else
                    begin
                        cand[0].ttype = stok_pkg::TT_ASSIGN;
                        apply_idle    = 1'b1;
                    end
                end
                M_SLASH:
                begin
                    if (ch_reg == "/")
                    begin
                        mode_next = M_LINE;
                    end
                    else if (ch_reg == "*")
                    begin
                        mode_next = M_BLOCK;
                    end
                    else
                    begin
                        // lone slash: error, and the character is dropped
                        cand_v[0] = 1'b1;
                        mode_next = M_IDLE;
                    end
                end
                M_LINE:
                begin
                    if (ch_reg == 8'd10)
                        mode_next = M_IDLE;
                end
                M_BLOCK:
                begin
                    if (ch_reg == "*")
                        mode_next = M_BLOCK_STAR;
                end
                M_BLOCK_STAR:
                begin
                    if (ch_reg == "/")
                        mode_next = M_IDLE;
                    else if (ch_reg != "*")
                        mode_next = M_BLOCK;
                end
                default:
                begin
                    apply_idle = 1'b1;
                end
            endcase

            if (apply_idle)
            begin
                mode_next = idle_mode;
                cand_v[1] = idle_emit;
                cand[1]   = idle_tok;
                if (idle_mode != M_IDLE)
                    start_next = pos_reg;
                if (idle_mode == M_STR)
                    len_next = 16'd1;
                if (idle_mode == M_WORD)
                begin
                    len_next    = 16'd1;
                    hash_next   = {24'd0, ch_reg};
                    prefix_next = PW'(ch_reg);
                    ident_next  = alpha;
                end
            end
        end

        pos_a = pos_reg + 16'(has_reg);
        pos_next = pos_a;

        if (eos_reg)
        begin
            // close whatever is open, then the end token
            cand[2].pos = start_next;
            unique case (mode_next)
                M_WORD:
                begin
                    cand_v[2] = 1'b1;
                    cand[2]   = finish_word(start_next, len_next, hash_next,
                                            prefix_next, ident_next);
                end
                M_STR, M_STR_ESC:
                begin
                    cand_v[2]     = 1'b1;
                    cand[2].ttype = stok_pkg::TT_STRING;
                    cand[2].len   = len_next;
                end
                M_EQ_PEND:
                begin
                    cand_v[2]     = 1'b1;
                    cand[2].ttype = stok_pkg::TT_ASSIGN;
                end
                M_SLASH:
                begin
                    cand_v[2] = 1'b1;
                end
                default:
                begin
                    cand_v[2] = 1'b0;
                end
            endcase
            cand_v[3]     = 1'b1;
            cand[3].ttype = stok_pkg::TT_END;
            cand[3].pos   = pos_a;
            cand[3].len   = 16'd0;

            mode_next   = M_IDLE;
            pos_next    = 16'd0;
            start_next  = 16'd0;
            len_next    = 16'd0;
            hash_next   = 32'd0;
            prefix_next = '0;
            ident_next  = 1'b0;
        end
    end

    // pack up to three tokens in order
    always_comb
    begin
        n_tok = 2'd0;
        for (int k = 0; k < 3; k++)
            slot_next[k] = cand[3];
        for (int i = 0; i < 4; i++)
        begin
            if (cand_v[i] && n_tok != 2'd3)
            begin
                slot_next[n_tok] = cand[i];
                n_tok = n_tok + 2'd1;
            end
        end
    end

    // handshake
    assign tok_valid  = idx_reg < cnt_reg;
    assign out_last   = idx_reg == (cnt_reg - 2'd1);
    assign pop        = tok_valid && !tok_stall;
    assign buf_free   = !tok_valid || (pop && out_last);
    assign process    = in_v_reg && buf_free;
    assign src_stall  = in_v_reg && !process;
    assign src_accept = src_valid && !src_stall;
    assign cnt_next   = process ? n_tok : cnt_reg;

    assign rd_idx      = (idx_reg == 2'd3) ? 2'd0 : idx_reg;
    assign rd_tok      = buf_reg[rd_idx];
    assign token_type  = rd_tok.ttype;
    assign token_pos   = rd_tok.pos;
    assign token_len   = rd_tok.len;
    assign ident_hash  = rd_tok.hash;
    assign last_of_run = out_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg   <= 1'b0;
            mode_reg   <= M_IDLE;
            pos_reg    <= 16'd0;
            start_reg  <= 16'd0;
            len_reg    <= 16'd0;
            hash_reg   <= 32'd0;
            prefix_reg <= '0;
            ident_reg  <= 1'b0;
            cnt_reg    <= 2'd0;
            idx_reg    <= 2'd0;
        end
        else
        begin
            if (src_accept)
                in_v_reg <= 1'b1;
            else if (process)
                in_v_reg <= 1'b0;

            if (process)
            begin
                mode_reg   <= mode_next;
                pos_reg    <= pos_next;
                start_reg  <= start_next;
                len_reg    <= len_next;
                hash_reg   <= hash_next;
                prefix_reg <= prefix_next;
                ident_reg  <= ident_next;
                idx_reg    <= 2'd0;
            end
            else if (pop)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_accept)
        begin
            ch_reg  <= ch;
            has_reg <= has_char;
            eos_reg <= end_of_source;
        end
        if (process)
        begin
            for (int k = 0; k < 3; k++)
                buf_reg[k] <= slot_next[k];
        end
    end

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= cnt_reg)
        else $error("result index ran past token count");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && token_type == stok_pkg::TT_END) |-> last_of_run)
        else $error("end token is not the last of its run");

    a_hash_ident: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && token_type != stok_pkg::TT_IDENT) |-> ident_hash == 32'd0)
        else $error("hash on a token that is not an identifier");

    a_eos_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (process && eos_reg) |=> (mode_reg == M_IDLE && pos_reg == 16'd0))
        else $error("scan state not cleared after end of source");

endmodule
